// ===== rtl/core/dedup_event_ring_log_macros.svh =====
// Assertion macros for the checker file of the event ring log.
// Needs nothing else; include once per file that asserts.
`ifndef DEDUP_EVENT_RING_LOG_MACROS_SVH
`define DEDUP_EVENT_RING_LOG_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define DERL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DERL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/derl_pkg.sv =====
// Shared types and constants for the deduplicating event ring log.
// No dependencies; the top level, the ring control and the checker import it.
package derl_pkg;

  localparam int DEF_DEPTH         = 16;
  localparam int DEF_REASON_BITS   = 32;
  localparam int DEF_SNAPSHOT_BITS = 64;

  localparam int STATE_BITS = 2;
  localparam int TIME_BITS  = 32;

  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  localparam logic [STATE_BITS-1:0] STATE_NORMAL = 2'd0;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  // Per-beat decisions handed from the control unit to the top level.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic was_written;
    logic not_found;
  } derl_ctl_t;

endpackage

// ===== rtl/core/dedup_event_ring_log.sv =====
// Top level of the deduplicating event ring log: handshake, pipeline, output register.
// Depends on derl_pkg, derl_ram and derl_ctrl.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------------------
//   in_     | sink      | in_valid/in_stall  | kind, state, reason, time, sensor, index
//   out_    | source    | out_valid/out_stall| status, written, count, record fields
//
// One beat per cycle in, one per cycle out while out_stall is low; an accepted in
// beat passes through stage 1 (the record RAM read is registered) and then the
// result register, which raises out_valid.
// Reset (rst_n low, synchronous) empties the ring and clears the dedup base;
// record memory contents are left as they are and never read before written.
// out_stall backs up through the result stage into in_stall in the same cycle.
module dedup_event_ring_log
  import derl_pkg::*;
#(
  parameter int DEPTH         = DEF_DEPTH,
  parameter int REASON_BITS   = DEF_REASON_BITS,
  parameter int SNAPSHOT_BITS = DEF_SNAPSHOT_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_kind,
  input  logic [STATE_BITS-1:0]      in_event_state,
  input  logic [REASON_BITS-1:0]     in_reason_code,
  input  logic [TIME_BITS-1:0]       in_time_stamp,
  input  logic [SNAPSHOT_BITS-1:0]   in_sensor_word,
  input  logic [$clog2(DEPTH)-1:0]   in_read_index,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_status,
  output logic                       out_was_written,
  output logic [$clog2(DEPTH+1)-1:0] out_entry_count,
  output logic [STATE_BITS-1:0]      out_state,
  output logic [REASON_BITS-1:0]     out_reason,
  output logic [TIME_BITS-1:0]       out_time,
  output logic [SNAPSHOT_BITS-1:0]   out_sensor
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = STATE_BITS + REASON_BITS + TIME_BITS + SNAPSHOT_BITS;

  // record word layout, LSB first: sensor, time, reason, state
  localparam int SEN_LO = 0;
  localparam int TIM_LO = SEN_LO + SNAPSHOT_BITS;
  localparam int RSN_LO = TIM_LO + TIME_BITS;
  localparam int STA_LO = RSN_LO + REASON_BITS;

  logic          accept;
  logic          out_free;
  derl_ctl_t     ctl;
  logic [AW-1:0] addr;
  logic [CW-1:0] count;
  logic [WW-1:0] wdata;
  logic [WW-1:0] rdata;
  logic          show_rec;

  // stage 1: RAM read in flight
  logic          s1_v_r, s1_v_nxt;
  logic          s1_kind_r;
  logic          s1_nf_r;
  logic          s1_ww_r;
  logic [CW-1:0] s1_cnt_r;

  // result register
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_status_r;
  logic                     out_ww_r;
  logic [CW-1:0]            out_cnt_r;
  logic [STATE_BITS-1:0]    out_state_r;
  logic [REASON_BITS-1:0]   out_reason_r;
  logic [TIME_BITS-1:0]     out_time_r;
  logic [SNAPSHOT_BITS-1:0] out_sensor_r;

  // result register can load when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;
  // stage 1 can take a beat when empty or moving on
  assign in_stall = s1_v_r && !out_free;
  assign accept   = in_valid && !in_stall;

  derl_ctrl #(
    .DEPTH       (DEPTH),
    .REASON_BITS (REASON_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .kind        (in_kind),
    .event_state (in_event_state),
    .reason      (in_reason_code),
    .read_index  (in_read_index),
    .ctl         (ctl),
    .addr        (addr),
    .count       (count)
  );

  assign wdata = {in_event_state, in_reason_code, in_time_stamp, in_sensor_word};

  // Only one beat per cycle, so a read and a write never hit the RAM together.
  derl_ram #(
    .WIDTH (WW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (addr),
    .wdata (wdata),
    .re    (ctl.rd_en),
    .raddr (addr),
    .rdata (rdata)
  );

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (accept) begin
      s1_v_nxt = 1'b1;
    end else if (out_free) begin
      s1_v_nxt = 1'b0;
    end
    out_valid_nxt = out_free ? s1_v_r : out_valid_r;
  end

  // Record fields go out only for a successful read; everything else shows zero.
  assign show_rec = (s1_kind_r == KIND_READ) && !s1_nf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= in_kind;
      s1_nf_r   <= ctl.not_found;
      s1_ww_r   <= ctl.was_written;
      s1_cnt_r  <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_v_r) begin
      out_status_r <= s1_nf_r ? STATUS_NOT_FOUND : STATUS_OK;
      out_ww_r     <= s1_ww_r;
      out_cnt_r    <= s1_cnt_r;
      out_state_r  <= show_rec ? rdata[STA_LO +: STATE_BITS]    : '0;
      out_reason_r <= show_rec ? rdata[RSN_LO +: REASON_BITS]   : '0;
      out_time_r   <= show_rec ? rdata[TIM_LO +: TIME_BITS]     : '0;
      out_sensor_r <= show_rec ? rdata[SEN_LO +: SNAPSHOT_BITS] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_was_written = out_ww_r;
  assign out_entry_count = out_cnt_r;
  assign out_state       = out_state_r;
  assign out_reason      = out_reason_r;
  assign out_time        = out_time_r;
  assign out_sensor      = out_sensor_r;

endmodule

// ===== rtl/core/derl_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module derl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read enable.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/derl_ctrl.sv =====
// Ring control: head pointer, fill count, dedup base and slot address math.
// Depends on derl_pkg.
module derl_ctrl
  import derl_pkg::*;
#(
  parameter int DEPTH       = DEF_DEPTH,
  parameter int REASON_BITS = DEF_REASON_BITS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       accept,
  input  logic                       kind,
  input  logic [STATE_BITS-1:0]      event_state,
  input  logic [REASON_BITS-1:0]     reason,
  input  logic [$clog2(DEPTH)-1:0]   read_index,
  output derl_ctl_t                  ctl,
  output logic [$clog2(DEPTH)-1:0]   addr,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 2;

  logic [AW-1:0]          head_r, head_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [STATE_BITS-1:0]  prior_state_r, prior_state_nxt;
  logic [REASON_BITS-1:0] prior_reason_r, prior_reason_nxt;

  logic          is_update;
  logic          is_normal;
  logic          dup;
  logic          do_write;
  logic          not_found;
  logic [AW-1:0] head_inc;
  logic [CW-1:0] count_inc;
  logic [SW-1:0] slot_sum;
  logic [AW-1:0] rd_slot;

  assign is_update = (kind == KIND_UPDATE);
  assign is_normal = (event_state == STATE_NORMAL);
  assign dup       = (event_state == prior_state_r) && (reason == prior_reason_r);
  assign do_write  = is_update && !is_normal && !dup;
  assign not_found = !is_update && (CW'(read_index) >= count_r);

  assign head_inc  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign count_inc = (count_r == CW'(DEPTH)) ? count_r : count_r + 1'b1;

  // oldest + index = head + DEPTH - count + index; below 2*DEPTH when index < count
  assign slot_sum = SW'(head_r) + SW'(DEPTH) - SW'(count_r) + SW'(read_index);
  assign rd_slot  = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH)) : AW'(slot_sum);

  assign addr  = is_update ? head_r : rd_slot;
  assign count = do_write ? count_inc : count_r;

  assign ctl.wr_en       = accept && do_write;
  assign ctl.rd_en       = accept && !is_update && !not_found;
  assign ctl.was_written = do_write;
  assign ctl.not_found   = not_found;

  always_comb begin
    head_nxt         = head_r;
    count_nxt        = count_r;
    prior_state_nxt  = prior_state_r;
    prior_reason_nxt = prior_reason_r;
    if (accept && is_update) begin
      if (is_normal) begin
        prior_state_nxt  = STATE_NORMAL;
        prior_reason_nxt = '0;
      end else if (do_write) begin
        head_nxt         = head_inc;
        count_nxt        = count_inc;
        prior_state_nxt  = event_state;
        prior_reason_nxt = reason;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r         <= '0;
      count_r        <= '0;
      prior_state_r  <= STATE_NORMAL;
      prior_reason_r <= '0;
    end else begin
      head_r         <= head_nxt;
      count_r        <= count_nxt;
      prior_state_r  <= prior_state_nxt;
      prior_reason_r <= prior_reason_nxt;
    end
  end

endmodule

// ===== rtl/core/derl_checker.sv =====
// Port-level checks for dedup_event_ring_log, bound onto the top level.
// Depends on derl_pkg and dedup_event_ring_log_macros.svh.
`include "dedup_event_ring_log_macros.svh"

module derl_checker
  import derl_pkg::*;
#(
  parameter int DEPTH         = DEF_DEPTH,
  parameter int REASON_BITS   = DEF_REASON_BITS,
  parameter int SNAPSHOT_BITS = DEF_SNAPSHOT_BITS
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic                       out_status,
  input logic                       out_was_written,
  input logic [$clog2(DEPTH+1)-1:0] out_entry_count,
  input logic [STATE_BITS-1:0]      out_state,
  input logic [REASON_BITS-1:0]     out_reason,
  input logic [TIME_BITS-1:0]       out_time,
  input logic [SNAPSHOT_BITS-1:0]   out_sensor
);

  localparam int CW = $clog2(DEPTH + 1);

  // stalled result beat holds
  `DERL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_was_written) && $stable(out_entry_count) && $stable(out_state) && $stable(out_reason) && $stable(out_time) && $stable(out_sensor), "result beat changed while stalled")

  // not_found carries no record and no write
  `DERL_ASSERT_NOW(a_nf_zero, clk, rst_n, out_valid && (out_status == STATUS_NOT_FOUND), !out_was_written && (out_state == '0) && (out_reason == '0) && (out_time == '0) && (out_sensor == '0), "not_found beat carries data")

  // an appended record leaves the ring non-empty
  `DERL_ASSERT_NOW(a_wr_count, clk, rst_n, out_valid && out_was_written, (out_status == STATUS_OK) && (out_entry_count != '0), "write reported with empty ring")

  // count never passes the ring depth
  `DERL_ASSERT_NOW(a_count_max, clk, rst_n, out_valid, out_entry_count <= CW'(DEPTH), "entry count above depth")

endmodule

bind dedup_event_ring_log derl_checker #(
  .DEPTH         (DEPTH),
  .REASON_BITS   (REASON_BITS),
  .SNAPSHOT_BITS (SNAPSHOT_BITS)
) u_derl_checker (.*);
